// ===== rtl/core/psc_pkg.sv =====
// ============================================================================
// psc_pkg - shared types and constants of the postfix stack calculator
// Opcodes, status codes, beat layouts and the sequencer/ALU state types.
// ============================================================================
package psc_pkg;

    localparam int WORD_W      = 32;
    localparam int OP_W        = 3;
    localparam int ST_W        = 2;
    localparam int DEPTH_OUT_W = 7;
    localparam int DIV_STEPS   = 32;
    localparam int CNT_W       = $clog2(DIV_STEPS);

    // input beat: operation, value; output beat: top_value, status, depth
    localparam int IN_FIELDS_W  = OP_W + WORD_W;
    localparam int OUT_FIELDS_W = WORD_W + ST_W + DEPTH_OUT_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef logic [OP_W-1:0]   t_opcode;
    typedef logic [ST_W-1:0]   t_status;
    typedef logic [WORD_W-1:0] t_word;

    localparam t_opcode OP_PUSH = 3'd0;
    localparam t_opcode OP_ADD  = 3'd1;
    localparam t_opcode OP_SUB  = 3'd2;
    localparam t_opcode OP_MUL  = 3'd3;
    localparam t_opcode OP_DIV  = 3'd4;
    localparam t_opcode OP_POP  = 3'd5;

    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_UNDERFLOW = 2'd1;
    localparam t_status ST_DIVZERO   = 2'd2;
    localparam t_status ST_FULL      = 2'd3;

    localparam t_word EMPTY_READ = '1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_POP_RD,
        S_B_RD,
        S_A_RD,
        S_ALU_GO,
        S_ALU_WAIT,
        S_WRITE,
        S_RESULT
    } t_seq_state;

    typedef enum logic [1:0] {
        A_IDLE,
        A_DIV,
        A_FIX,
        A_DONE
    } t_alu_state;

    typedef struct packed {
        logic    start;
        t_opcode op;
    } t_alu_req;

    typedef struct packed {
        logic  done;
        t_word result;
    } t_alu_rsp;

endpackage

// ===== rtl/core/psc_stack.sv =====
// ============================================================================
// psc_stack - operand store
// One write port, one read port with registered read data.
// ============================================================================
module psc_stack #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  logic                i_clk,
    input  logic                i_wr_en,
    input  logic [ADDR_W-1:0]   i_wr_addr,
    input  psc_pkg::t_word      i_wr_data,
    input  logic [ADDR_W-1:0]   i_rd_addr,
    output psc_pkg::t_word      o_rd_data
);
    import psc_pkg::*;

    t_word r_mem [DEPTH];
    t_word r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/core/psc_alu.sv =====
// ============================================================================
// psc_alu - shared arithmetic unit
// Add, subtract and low-word multiply into a result register; signed divide
// by a radix-2 restoring loop, one quotient bit per cycle, then a sign fix.
// ============================================================================
module psc_alu (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  psc_pkg::t_alu_req  i_req,
    input  psc_pkg::t_word     i_a,
    input  psc_pkg::t_word     i_b,
    output psc_pkg::t_alu_rsp  o_rsp
);
    import psc_pkg::*;

    t_alu_state       r_state, n_state;
    t_word            r_res;
    t_word            r_rem;
    t_word            r_quo;
    t_word            r_dvsr;
    logic             r_neg;
    logic [CNT_W-1:0] r_cnt;

    logic [WORD_W-1:0] w_rem_sh;
    logic [WORD_W:0]   w_diff;
    t_word             w_mag_a;
    t_word             w_mag_b;

    assign w_mag_a  = i_a[WORD_W-1] ? (t_word'(0) - i_a) : i_a;
    assign w_mag_b  = i_b[WORD_W-1] ? (t_word'(0) - i_b) : i_b;
    // remainder stays below the divisor (<= 2^31), so the shift fits a word
    assign w_rem_sh = {r_rem[WORD_W-2:0], r_quo[WORD_W-1]};
    assign w_diff   = {1'b0, w_rem_sh} - {1'b0, r_dvsr};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            A_IDLE: begin
                if (i_req.start) begin
                    n_state = (i_req.op == OP_DIV) ? A_DIV : A_DONE;
                end
            end
            A_DIV: begin
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = A_FIX;
                end
            end
            A_FIX:  n_state = A_DONE;
            A_DONE: n_state = A_IDLE;
            default: n_state = A_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            A_IDLE: begin
                r_rem  <= '0;
                r_quo  <= w_mag_a;
                r_dvsr <= w_mag_b;
                r_neg  <= i_a[WORD_W-1] ^ i_b[WORD_W-1];
                r_cnt  <= '0;
                case (i_req.op)
                    OP_ADD:  r_res <= i_a + i_b;
                    OP_SUB:  r_res <= i_a - i_b;
                    OP_MUL:  r_res <= WORD_W'(i_a * i_b);
                    default: r_res <= '0;
                endcase
            end
            A_DIV: begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (!w_diff[WORD_W]) begin
                    r_rem <= w_diff[WORD_W-1:0];
                    r_quo <= {r_quo[WORD_W-2:0], 1'b1};
                end else begin
                    r_rem <= w_rem_sh;
                    r_quo <= {r_quo[WORD_W-2:0], 1'b0};
                end
            end
            A_FIX: begin
                r_res <= r_neg ? (t_word'(0) - r_quo) : r_quo;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_rsp.done   = (r_state == A_DONE);
        o_rsp.result = r_res;
    end

endmodule

// ===== rtl/core/postfix_stack_calculator_core.sv =====
// ============================================================================
// postfix_stack_calculator_core - reverse Polish integer evaluator
// Sequencer, operand stack and shared ALU with a registered output beat.
// ============================================================================
// Each input beat carries one item: push a value, add, subtract, multiply,
// divide (pop b, pop a, push a op b), or pop the top. Every item returns
// one output beat with the value pushed, computed or popped, a status
// (ok, underflow, divide by zero, stack full) and the stack depth after the
// item. Arithmetic wraps at 32 bits; division truncates toward zero. A
// missing operand reads as -1 with underflow status; divide by zero leaves
// the stack untouched; a push onto a full stack is dropped. One item is in
// work at a time and the input is not ready meanwhile. A divide runs the
// 32-step radix-2 loop of the shared ALU; pop and the arithmetic items
// read their operands through the registered read port of the operand
// store. A new item is taken while the previous output beat still waits
// downstream. The operand store needs no clearing after reset: only
// entries below the current depth are ever used.
// ============================================================================
module postfix_stack_calculator_core #(
    parameter int STACK_DEPTH = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // slave side
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // [2:0] operation, [34:3] value, [39:35] zero
    input  logic [psc_pkg::IN_TDATA_W-1:0]      i_s_axis_tdata,
    // master side
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // [31:0] top_value, [33:32] status, [40:34] depth, [47:41] zero
    output logic [psc_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata
);
    import psc_pkg::*;

    localparam int D_W = $clog2(STACK_DEPTH + 1);   // holds the full count
    localparam int A_W = $clog2(STACK_DEPTH);       // store address

    // ---------------------------------------------------------------------
    // state and item registers
    // ---------------------------------------------------------------------
    t_seq_state  r_state, n_state;
    t_opcode     r_op;
    t_word       r_val;
    t_word       r_a;
    t_word       r_b;
    t_word       r_res;
    t_status     r_status;
    logic [D_W-1:0] r_depth;

    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    // ---------------------------------------------------------------------
    // control toward store and ALU
    // ---------------------------------------------------------------------
    logic           w_accept;
    logic           w_out_free;
    logic           w_mem_we;
    logic [A_W-1:0] w_mem_waddr;
    t_word          w_mem_wdata;
    logic [A_W-1:0] w_mem_raddr;
    t_word          w_rd_data;
    t_alu_req       w_alu_req;
    t_alu_rsp       w_alu_rsp;

    logic w_is_arith;
    logic w_full;
    logic w_empty;
    logic w_has_a;      // a second operand is on the stack (checked in S_B_RD)
    logic w_div_zero;

    assign w_accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free = !r_out_valid || i_m_axis_tready;
    assign w_is_arith = (r_op == OP_ADD) || (r_op == OP_SUB) ||
                        (r_op == OP_MUL) || (r_op == OP_DIV);
    assign w_full     = (r_depth == D_W'(STACK_DEPTH));
    assign w_empty    = (r_depth == '0);
    assign w_has_a    = (r_depth >= D_W'(2));
    assign w_div_zero = (r_op == OP_DIV) && (w_rd_data == '0);

    // ---------------------------------------------------------------------
    // next state
    // ---------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (r_op == OP_POP) begin
                    n_state = w_empty ? S_RESULT : S_POP_RD;
                end else if (w_is_arith) begin
                    n_state = w_empty ? S_ALU_GO : S_B_RD;
                end else begin
                    n_state = S_RESULT;     // push, or an unused code
                end
            end
            S_POP_RD: n_state = S_RESULT;
            S_B_RD: begin
                if (w_div_zero) begin
                    n_state = S_RESULT;
                end else if (w_has_a) begin
                    n_state = S_A_RD;
                end else begin
                    n_state = S_ALU_GO;
                end
            end
            S_A_RD:   n_state = S_ALU_GO;
            S_ALU_GO: n_state = S_ALU_WAIT;
            S_ALU_WAIT: begin
                if (w_alu_rsp.done) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE:  n_state = S_RESULT;
            S_RESULT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // ---------------------------------------------------------------------
    // control outputs
    // ---------------------------------------------------------------------
    always_comb begin
        o_s_axis_tready = (r_state == S_IDLE);
        w_mem_we        = 1'b0;
        w_mem_waddr     = A_W'(r_depth);
        w_mem_wdata     = r_res;
        // top entry, or the one below it while b is coming back
        w_mem_raddr     = (r_state == S_B_RD) ? A_W'(r_depth - D_W'(2))
                                              : A_W'(r_depth - D_W'(1));
        w_alu_req.start = 1'b0;
        w_alu_req.op    = r_op;
        unique case (r_state)
            S_DECODE: begin
                if (r_op == OP_PUSH && !w_full) begin
                    w_mem_we    = 1'b1;
                    w_mem_wdata = r_val;
                end
            end
            S_ALU_GO: w_alu_req.start = 1'b1;
            S_WRITE:  w_mem_we        = 1'b1;
            default: begin
            end
        endcase
    end

    // ---------------------------------------------------------------------
    // sequencer registers
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_depth <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_DECODE: begin
                    if ((r_op == OP_PUSH && !w_full) ||
                        (r_op == OP_POP && !w_empty)) begin
                        r_depth <= (r_op == OP_PUSH) ? r_depth + D_W'(1)
                                                     : r_depth - D_W'(1);
                    end
                end
                S_B_RD: begin
                    if (!w_div_zero) begin
                        r_depth <= r_depth - D_W'(1);
                    end
                end
                S_A_RD:  r_depth <= r_depth - D_W'(1);
                S_WRITE: r_depth <= r_depth + D_W'(1);
                default: begin
                end
            endcase
        end
    end

    // item payload
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_op     <= i_s_axis_tdata[OP_W-1:0];
                r_val    <= i_s_axis_tdata[OP_W +: WORD_W];
                r_res    <= '0;
                r_status <= ST_OK;
            end
            S_DECODE: begin
                if (r_op == OP_PUSH) begin
                    if (w_full) begin
                        r_status <= ST_FULL;
                    end else begin
                        r_res <= r_val;
                    end
                end else if (w_empty && (r_op == OP_POP || w_is_arith)) begin
                    // both operands missing, or pop of an empty stack
                    r_res    <= EMPTY_READ;
                    r_a      <= EMPTY_READ;
                    r_b      <= EMPTY_READ;
                    r_status <= ST_UNDERFLOW;
                end
            end
            S_POP_RD: r_res <= w_rd_data;
            S_B_RD: begin
                r_b <= w_rd_data;
                if (w_div_zero) begin
                    r_status <= ST_DIVZERO;
                end else if (!w_has_a) begin
                    r_a      <= EMPTY_READ;
                    r_status <= ST_UNDERFLOW;
                end
            end
            S_A_RD: r_a <= w_rd_data;
            S_ALU_WAIT: begin
                if (w_alu_rsp.done) begin
                    r_res <= w_alu_rsp.result;
                end
            end
            default: begin
            end
        endcase
    end

    // ---------------------------------------------------------------------
    // output beat register
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_RESULT && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_RESULT && w_out_free) begin
            r_out_data <= {(OUT_TDATA_W - OUT_FIELDS_W)'(0),
                           DEPTH_OUT_W'(r_depth), r_status, r_res};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // ---------------------------------------------------------------------
    // operand store and shared ALU
    // ---------------------------------------------------------------------
    psc_stack #(
        .DEPTH  (STACK_DEPTH),
        .ADDR_W (A_W)
    ) u_stack (
        .i_clk     (i_clk),
        .i_wr_en   (w_mem_we),
        .i_wr_addr (w_mem_waddr),
        .i_wr_data (w_mem_wdata),
        .i_rd_addr (w_mem_raddr),
        .o_rd_data (w_rd_data)
    );

    psc_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_alu_req),
        .i_a     (r_a),
        .i_b     (r_b),
        .o_rsp   (w_alu_rsp)
    );

    // ---------------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------------
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= D_W'(STACK_DEPTH))
        else $error("stack count beyond capacity");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_s_axis_tready)
        else $error("second item taken while one is in work");

    a_write_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mem_we |-> !w_full)
        else $error("store write with a full stack");

    a_full_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[WORD_W +: ST_W] == ST_FULL) |->
        (o_m_axis_tdata[WORD_W + ST_W +: DEPTH_OUT_W] ==
         DEPTH_OUT_W'(STACK_DEPTH)))
        else $error("full status with a stack that is not full");

endmodule
